// ===== rtl/ckt_pkg.sv =====
// Shared types and codes for the client keepalive table.
// Used by the top level; no dependencies.
`default_nettype none
package ckt_pkg;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_REPLY     = 3'd1,
        MODE_ADD       = 3'd2,
        MODE_REMOVE_IP = 3'd3,
        MODE_REMOVE_ID = 3'd4,
        MODE_UNUSED5   = 3'd5,
        MODE_UNUSED6   = 3'd6,
        MODE_UNUSED7   = 3'd7
    } t_mode;

    typedef enum logic [3:0] {
        EV_PROBE      = 4'd0,
        EV_TIMEOUT    = 4'd1,
        EV_ADDED      = 4'd2,
        EV_DUPLICATE  = 4'd3,
        EV_FULL       = 4'd4,
        EV_REMOVED    = 4'd5,
        EV_NOT_FOUND  = 4'd6,
        EV_REPLY_OK   = 4'd7,
        EV_UNEXPECTED = 4'd8,
        EV_UNKNOWN    = 4'd9,
        EV_DONE       = 4'd10
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_RETRY    = 2'd2;

    localparam logic [15:0] INTERVAL_RST = 16'd1000;
    localparam logic [19:0] TIMEOUT_RST  = 20'd10000;
    localparam logic [6:0]  RETRY_RST    = 7'd5;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] ident;
        logic [31:0] last_heard;
        logic [31:0] probe_sent;
        logic        awaiting;
        logic [7:0]  retry;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/ckt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ckt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/client_keepalive_table_top.sv =====
// Client keepalive table: peer table with heartbeat probing and timeouts.
// Depends on ckt_pkg and ckt_ram.
//
// Usage: present a request on i_mode/i_tick_ms/i_peer_ip/i_peer_port/
// i_client_id with start high; it is taken at an edge where busy is low.
// Results come out one per cycle on the o_ ports, each marked by o_valid
// for exactly one cycle; the receiver cannot stall them. o_final_result
// flags the last result of a request.
// Ticks, replies, adds and removes walk every slot of the entry memory
// through its single read port, one slot per cycle, then close; busy
// stays high through the walk and the close, so the next request is
// taken only after that. A tick emits its probe and timeout results
// during the walk and a done result at the end; other requests emit one
// result at the end. Unused modes skip the walk and go to the close.
// Configuration writes (i_cfg_wr_en) take effect at once and are to be
// made while busy is low; the block itself does not enforce this. Reset
// clears the valid bits, server time and id counter and loads the config
// defaults; the entry memory needs no clearing: only valid slots are used.
`default_nettype none
module client_keepalive_table_top #(
    parameter int MAX_CLIENTS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_tick_ms,
    input  wire logic [31:0] i_peer_ip,
    input  wire logic [15:0] i_peer_port,
    input  wire logic [15:0] i_client_id,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [3:0]       o_event_kind,
    output logic [15:0]      o_out_id,
    output logic [31:0]      o_out_ip,
    output logic [15:0]      o_out_port,
    output logic [31:0]      o_stamp_ms,
    output logic [31:0]      o_ping_ms,
    output logic [7:0]       o_retry_now,
    output logic             o_final_result
);
    localparam int SW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(MAX_CLIENTS - 1);
    localparam int EW = $bits(ckt_pkg::t_entry);

    ckt_pkg::t_state r_state, n_state;
    ckt_pkg::t_mode  r_mode;
    logic [31:0] r_ip;
    logic [15:0] r_port, r_cid;
    logic [31:0] r_time, n_time;
    logic [15:0] r_next_id, n_next_id;
    logic [MAX_CLIENTS-1:0] r_valid, n_valid;
    logic [15:0] r_interval;
    logic [19:0] r_timeout;
    logic [6:0]  r_limit;

    logic [SW-1:0] r_addr, n_addr;
    logic          r_issue, n_issue;
    logic          r_dv, n_dv;
    logic [SW-1:0] r_didx;
    logic          r_found, n_found;
    logic [SW-1:0] r_fidx, n_fidx;
    ckt_pkg::t_entry r_fent, n_fent;
    logic          r_free, n_free;
    logic [SW-1:0] r_freeidx, n_freeidx;

    logic               n_valid_o;
    ckt_pkg::t_event    n_event;
    logic [15:0]        n_id_o, n_port_o;
    logic [31:0]        n_ip_o, n_ping_o;
    logic [7:0]         n_retry_o;
    logic               n_final_o;
    ckt_pkg::t_event    r_event;

    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    ckt_pkg::t_entry    wr_ent;
    logic [EW-1:0]      rd_word;
    ckt_pkg::t_entry    rd_ent;

    logic [31:0] elapsed;
    logic [24:0] probe_gap;
    logic        slot_valid, addr_hit, id_hit, hit;
    logic        accept;

    assign accept = start && !busy;
    assign rd_ent = ckt_pkg::t_entry'(rd_word);

    ckt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CLIENTS)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_ent),
        .i_rd_en   (r_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_word)
    );

    // Slot timing and matching on the word just read.
    always_comb begin
        elapsed    = r_time - rd_ent.last_heard;
        probe_gap  = 25'(r_interval) * (25'(rd_ent.retry) + 25'd1);
        slot_valid = r_valid[r_didx];
        addr_hit   = slot_valid && rd_ent.ip == r_ip && rd_ent.port == r_port;
        id_hit     = slot_valid && rd_ent.ident == r_cid;
        hit        = (r_mode == ckt_pkg::MODE_REMOVE_ID) ? id_hit : addr_hit;
    end

    always_comb begin
        n_state   = r_state;
        n_time    = r_time;
        n_next_id = r_next_id;
        n_valid   = r_valid;
        n_addr    = r_addr;
        n_issue   = 1'b0;
        n_dv      = 1'b0;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_fent    = r_fent;
        n_free    = r_free;
        n_freeidx = r_freeidx;
        n_valid_o = 1'b0;
        n_event   = ckt_pkg::EV_DONE;
        n_id_o    = '0;
        n_ip_o    = '0;
        n_port_o  = '0;
        n_ping_o  = '0;
        n_retry_o = '0;
        n_final_o = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_didx;
        wr_ent    = rd_ent;

        unique case (r_state)
            ckt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_found = 1'b0;
                    n_free  = 1'b0;
                    n_addr  = '0;
                    if (ckt_pkg::t_mode'(i_mode) == ckt_pkg::MODE_TICK) begin
                        n_time = r_time + 32'(i_tick_ms);
                    end
                    if (i_mode > 3'(ckt_pkg::MODE_REMOVE_ID)) begin
                        n_state = ckt_pkg::ST_FINISH;
                    end else begin
                        n_state = ckt_pkg::ST_SCAN;
                        n_issue = 1'b1;
                    end
                end
            end
            ckt_pkg::ST_SCAN: begin
                // Issue reads for slots 0..LAST, then process each in the cycle after its read.
                if (r_issue) begin
                    n_dv = 1'b1;
                    if (r_addr != LAST) begin
                        n_addr  = r_addr + 1'b1;
                        n_issue = 1'b1;
                    end
                end
                if (r_dv) begin
                    if (r_didx == LAST) begin
                        n_state = ckt_pkg::ST_FINISH;
                    end
                    if (r_mode == ckt_pkg::MODE_TICK) begin
                        if (slot_valid && elapsed >= 32'(r_interval)) begin
                            n_id_o   = rd_ent.ident;
                            n_ip_o   = rd_ent.ip;
                            n_port_o = rd_ent.port;
                            if (elapsed >= 32'(r_timeout) || rd_ent.retry > 8'(r_limit)) begin
                                n_valid[r_didx] = 1'b0;
                                n_valid_o       = 1'b1;
                                n_event         = ckt_pkg::EV_TIMEOUT;
                            end else if (!rd_ent.awaiting || elapsed >= 32'(probe_gap)) begin
                                if (rd_ent.retry == 8'd0) begin
                                    wr_ent.probe_sent = r_time;
                                end
                                wr_ent.awaiting = 1'b1;
                                if (rd_ent.retry != 8'hFF) begin
                                    wr_ent.retry = rd_ent.retry + 8'd1;
                                end
                                wr_en     = 1'b1;
                                n_valid_o = 1'b1;
                                n_event   = ckt_pkg::EV_PROBE;
                                n_retry_o = wr_ent.retry;
                            end
                        end
                    end else begin
                        // Keep the lowest matching slot and the lowest free slot.
                        if (!r_found && hit) begin
                            n_found = 1'b1;
                            n_fidx  = r_didx;
                            n_fent  = rd_ent;
                        end
                        if (!r_free && !slot_valid) begin
                            n_free    = 1'b1;
                            n_freeidx = r_didx;
                        end
                    end
                end
            end
            ckt_pkg::ST_FINISH: begin
                n_state   = ckt_pkg::ST_IDLE;
                n_valid_o = 1'b1;
                n_final_o = 1'b1;
                n_ip_o    = r_ip;
                n_port_o  = r_port;
                case (r_mode)
                    ckt_pkg::MODE_REPLY: begin
                        if (!r_found) begin
                            n_event = ckt_pkg::EV_UNKNOWN;
                        end else begin
                            n_id_o   = r_fent.ident;
                            n_ip_o   = r_fent.ip;
                            n_port_o = r_fent.port;
                            if (!r_fent.awaiting) begin
                                n_event = ckt_pkg::EV_UNEXPECTED;
                            end else begin
                                n_event           = ckt_pkg::EV_REPLY_OK;
                                n_ping_o          = r_time - r_fent.probe_sent;
                                wr_en             = 1'b1;
                                wr_addr           = r_fidx;
                                wr_ent            = r_fent;
                                wr_ent.last_heard = r_time;
                                wr_ent.awaiting   = 1'b0;
                                wr_ent.retry      = '0;
                            end
                        end
                    end
                    ckt_pkg::MODE_ADD: begin
                        if (r_found) begin
                            n_event = ckt_pkg::EV_DUPLICATE;
                            n_id_o  = r_fent.ident;
                        end else if (!r_free) begin
                            n_event = ckt_pkg::EV_FULL;
                        end else begin
                            n_event              = ckt_pkg::EV_ADDED;
                            n_id_o               = r_next_id;
                            n_next_id            = r_next_id + 16'd1;
                            n_valid[r_freeidx]   = 1'b1;
                            wr_en                = 1'b1;
                            wr_addr              = r_freeidx;
                            wr_ent.ip            = r_ip;
                            wr_ent.port          = r_port;
                            wr_ent.ident         = r_next_id;
                            wr_ent.last_heard    = r_time;
                            wr_ent.probe_sent    = '0;
                            wr_ent.awaiting      = 1'b0;
                            wr_ent.retry         = '0;
                        end
                    end
                    ckt_pkg::MODE_REMOVE_IP, ckt_pkg::MODE_REMOVE_ID: begin
                        if (!r_found) begin
                            n_event = ckt_pkg::EV_NOT_FOUND;
                            if (r_mode == ckt_pkg::MODE_REMOVE_ID) begin
                                n_id_o = r_cid;
                            end
                        end else begin
                            n_event         = ckt_pkg::EV_REMOVED;
                            n_id_o          = r_fent.ident;
                            n_ip_o          = r_fent.ip;
                            n_port_o        = r_fent.port;
                            n_valid[r_fidx] = 1'b0;
                        end
                    end
                    default: begin
                        n_event  = ckt_pkg::EV_DONE;
                        n_ip_o   = '0;
                        n_port_o = '0;
                    end
                endcase
            end
            default: begin
                n_state = ckt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ckt_pkg::ST_IDLE;
            r_time     <= '0;
            r_next_id  <= '0;
            r_valid    <= '0;
            r_issue    <= 1'b0;
            r_dv       <= 1'b0;
            r_interval <= ckt_pkg::INTERVAL_RST;
            r_timeout  <= ckt_pkg::TIMEOUT_RST;
            r_limit    <= ckt_pkg::RETRY_RST;
            o_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_time    <= n_time;
            r_next_id <= n_next_id;
            r_valid   <= n_valid;
            r_issue   <= n_issue;
            r_dv      <= n_dv;
            o_valid   <= n_valid_o;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ckt_pkg::REG_INTERVAL: r_interval <= i_cfg_wdata[15:0];
                    ckt_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                    ckt_pkg::REG_RETRY:    r_limit    <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= ckt_pkg::t_mode'(i_mode);
            r_ip   <= i_peer_ip;
            r_port <= i_peer_port;
            r_cid  <= i_client_id;
        end
        r_addr         <= n_addr;
        r_didx         <= r_addr;
        r_found        <= n_found;
        r_fidx         <= n_fidx;
        r_fent         <= n_fent;
        r_free         <= n_free;
        r_freeidx      <= n_freeidx;
        r_event        <= n_event;
        o_out_id       <= n_id_o;
        o_out_ip       <= n_ip_o;
        o_out_port     <= n_port_o;
        o_stamp_ms     <= r_time;
        o_ping_ms      <= n_ping_o;
        o_retry_now    <= n_retry_o;
        o_final_result <= n_final_o;
    end

    assign busy         = (r_state != ckt_pkg::ST_IDLE);
    assign o_event_kind = r_event;

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ckt_pkg::ST_FINISH |=> o_valid && o_final_result)
        else $error("closing result missing after finish");

    a_midscan_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_result |->
            r_event == ckt_pkg::EV_PROBE || r_event == ckt_pkg::EV_TIMEOUT)
        else $error("non-final result of wrong kind");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_scan_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |=> r_dv && r_state == ckt_pkg::ST_SCAN)
        else $error("issued read not processed in scan");
endmodule
`default_nettype wire
